/* rtl/fantc_pkg.sv */
package fantc_pkg;

    localparam int WINDOW_TICKS_DEF   = 1000;
    localparam int PULSES_PER_REV_DEF = 2;

    localparam int TEMP_W  = 12;
    localparam int WIN_W   = 10;
    localparam int PCNT_W  = 16;
    localparam int RPM_W   = 21;
    localparam int DUTY_W  = 8;
    localparam int SPEED_W = 7;
    localparam int OFS_W   = 7;
    localparam int SCALE_W = 8;

    // shared divider: dividend wide enough for pulse_count * 60
    localparam int DVD_W   = 22;
    localparam int DVS_W   = 8;
    localparam int DCNT_W  = $clog2(DVD_W + 1);

    localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(100);
    localparam logic [DVS_W-1:0]   PCT_DIV   = DVS_W'(100);
    localparam logic [RPM_W-1:0]   RPM_MAX   = {RPM_W{1'b1}};
    localparam logic [DUTY_W-1:0]  DUTY_MAX  = {DUTY_W{1'b1}};
    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(10);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MAX    = 2'd3;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DVD_W-1:0]  quot;
    } t_div_rsp;

endpackage

/* rtl/fan_tach_and_temp_duty_control_top.sv */
// channel  | dir | handshake                       | payload, lowest bit first
// s_axis   | in  | s_axis_tvalid / s_axis_tready   | tach_level, thermostat_temp,
//          |     |                                 | room_temp, ms_tick
// m_axis   | out | m_axis_tvalid / m_axis_tready   | duty_cycle, fan_rpm, stall_error
// cfg      | in  | i_cfg_we (no ready)             | i_cfg_idx, i_cfg_wdata
//
// each sample goes through the duty division, and one that closes a counting
// window first goes through the rpm division; both run on the 22-step shared
// divider that does both the rpm scaling and the duty scaling.
// a new sample is taken while a finished result waits in the output register.
// reset is synchronous, active low, and clears the counters, state and config.
module fan_tach_and_temp_duty_control_top #(
    parameter int WINDOW_TICKS   = fantc_pkg::WINDOW_TICKS_DEF,
    parameter int PULSES_PER_REV = fantc_pkg::PULSES_PER_REV_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // tach_level[0], thermostat_temp[12:1], room_temp[24:13], ms_tick[25]
    input  logic [fantc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // duty_cycle[7:0], fan_rpm[28:8], stall_error[29]
    output logic [fantc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [fantc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fantc_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_RPM_GO    = 6'b000010,
        S_RPM_WAIT  = 6'b000100,
        S_DUTY_GO   = 6'b001000,
        S_DUTY_WAIT = 6'b010000,
        S_OUT       = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic                               r_manual_mode;
    logic [fantc_pkg::SPEED_W-1:0]      r_manual_speed;
    logic signed [fantc_pkg::OFS_W-1:0] r_temp_offset;
    logic [fantc_pkg::SCALE_W-1:0]      r_scale;

    // block state
    logic                               r_last_tach, n_last_tach;
    logic [fantc_pkg::PCNT_W-1:0]       r_pulse_cnt, n_pulse_cnt;
    logic [fantc_pkg::WIN_W-1:0]        r_win, n_win;
    logic [fantc_pkg::RPM_W-1:0]        r_rpm, n_rpm;
    logic [fantc_pkg::DUTY_W-1:0]       r_duty, n_duty;

    // per-sample work registers
    logic [fantc_pkg::DVD_W-1:0]        r_rpm_dvd, n_rpm_dvd;
    logic [fantc_pkg::PCNT_W-1:0]       r_duty_dvd, n_duty_dvd;
    logic [fantc_pkg::DVS_W-1:0]        r_duty_dvs, n_duty_dvs;
    logic [fantc_pkg::DUTY_W-1:0]       r_duty_new, n_duty_new;

    logic                               r_out_vld, n_out_vld;
    logic [fantc_pkg::OUT_DATA_W-1:0]   r_out_data, n_out_data;

    fantc_pkg::t_div_req div_req;
    fantc_pkg::t_div_rsp div_rsp;

    // input fields
    logic                                in_tach;
    logic signed [fantc_pkg::TEMP_W-1:0] in_thermo;
    logic signed [fantc_pkg::TEMP_W-1:0] in_room;
    logic                                in_tick;
    logic                                in_acc;

    logic [fantc_pkg::PCNT_W-1:0]        pcnt_edge;
    logic [fantc_pkg::WIN_W:0]           win_inc;
    logic                                win_close;
    logic signed [fantc_pkg::TEMP_W+1:0] cmp_rhs;
    logic signed [fantc_pkg::TEMP_W:0]   tdiff;
    logic                                room_hot;
    logic                                diff_pos;
    logic [fantc_pkg::DUTY_W-1:0]        diff_deg;
    logic [fantc_pkg::SPEED_W-1:0]       speed_sat;
    logic                                out_free;
    logic                                stall;

    assign in_tach   = s_axis_tdata[0];
    assign in_thermo = s_axis_tdata[12:1];
    assign in_room   = s_axis_tdata[24:13];
    assign in_tick   = s_axis_tdata[25];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual_mode  <= 1'b0;
            r_manual_speed <= '0;
            r_temp_offset  <= '0;
            r_scale        <= fantc_pkg::SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fantc_pkg::CFG_MANUAL_MODE:  r_manual_mode  <= i_cfg_wdata[0];
                fantc_pkg::CFG_MANUAL_SPEED: r_manual_speed <= i_cfg_wdata[fantc_pkg::SPEED_W-1:0];
                fantc_pkg::CFG_TEMP_OFFSET:  r_temp_offset  <= i_cfg_wdata[fantc_pkg::OFS_W-1:0];
                fantc_pkg::CFG_SCALE_MAX: begin
                    // a zero scale acts as one
                    r_scale <= (i_cfg_wdata == '0) ? fantc_pkg::SCALE_W'(1) : i_cfg_wdata;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        pcnt_edge = r_pulse_cnt;
        if (in_tach && !r_last_tach && (r_pulse_cnt != '1)) begin
            pcnt_edge = r_pulse_cnt + 1'b1;
        end
        win_inc   = {1'b0, r_win} + 1'b1;
        win_close = in_tick && (win_inc >= (fantc_pkg::WIN_W+1)'(WINDOW_TICKS));

        // thermostat plus whole-degree offset, in 1/16 degree
        cmp_rhs  = (fantc_pkg::TEMP_W+2)'(in_thermo)
                 + ((fantc_pkg::TEMP_W+2)'(r_temp_offset) <<< 4);
        room_hot = (fantc_pkg::TEMP_W+2)'(in_room) > cmp_rhs;
        tdiff    = (fantc_pkg::TEMP_W+1)'(in_room) - (fantc_pkg::TEMP_W+1)'(in_thermo);
        // at least one whole degree above; anything less truncates to zero duty
        diff_pos = !tdiff[fantc_pkg::TEMP_W] && (tdiff[fantc_pkg::TEMP_W-1:4] != '0);
        diff_deg = tdiff[fantc_pkg::TEMP_W-1:4];
        speed_sat = (r_manual_speed > fantc_pkg::SPEED_MAX) ? fantc_pkg::SPEED_MAX
                                                            : r_manual_speed;
    end

    always_comb begin
        n_state     = r_state;
        n_last_tach = r_last_tach;
        n_pulse_cnt = r_pulse_cnt;
        n_win       = r_win;
        n_rpm       = r_rpm;
        n_duty      = r_duty;
        n_rpm_dvd   = r_rpm_dvd;
        n_duty_dvd  = r_duty_dvd;
        n_duty_dvs  = r_duty_dvs;
        n_duty_new  = r_duty_new;
        n_out_vld   = r_out_vld;
        n_out_data  = r_out_data;
        stall       = (r_rpm == '0) && (r_duty != '0);

        div_req.start    = 1'b0;
        div_req.dividend = r_rpm_dvd;
        div_req.divisor  = fantc_pkg::DVS_W'(PULSES_PER_REV);

        if (r_out_vld && m_axis_tready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_last_tach = in_tach;
                    // pulse count times 60 as a shift and subtract
                    n_rpm_dvd = ({6'b0, pcnt_edge} << 6) - ({6'b0, pcnt_edge} << 2);
                    if (win_close) begin
                        n_pulse_cnt = '0;
                        n_win       = '0;
                        n_state     = S_RPM_GO;
                    end else begin
                        n_pulse_cnt = pcnt_edge;
                        n_win       = in_tick ? win_inc[fantc_pkg::WIN_W-1:0] : r_win;
                        n_state     = S_DUTY_GO;
                    end
                    if (r_manual_mode) begin
                        n_duty_dvd = ({9'b0, speed_sat} << 8) - {9'b0, speed_sat};
                        n_duty_dvs = fantc_pkg::PCT_DIV;
                    end else begin
                        n_duty_dvd = (room_hot && diff_pos)
                                   ? (({8'b0, diff_deg} << 8) - {8'b0, diff_deg}) : '0;
                        n_duty_dvs = r_scale;
                    end
                end
            end
            S_RPM_GO: begin
                div_req.start = 1'b1;
                n_state       = S_RPM_WAIT;
            end
            S_RPM_WAIT: begin
                if (div_rsp.done) begin
                    n_rpm   = div_rsp.quot[fantc_pkg::DVD_W-1:fantc_pkg::RPM_W] != '0
                            ? fantc_pkg::RPM_MAX : div_rsp.quot[fantc_pkg::RPM_W-1:0];
                    n_state = S_DUTY_GO;
                end
            end
            S_DUTY_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = {6'b0, r_duty_dvd};
                div_req.divisor  = r_duty_dvs;
                n_state          = S_DUTY_WAIT;
            end
            S_DUTY_WAIT: begin
                if (div_rsp.done) begin
                    n_duty_new = div_rsp.quot[fantc_pkg::DVD_W-1:fantc_pkg::DUTY_W] != '0
                               ? fantc_pkg::DUTY_MAX : div_rsp.quot[fantc_pkg::DUTY_W-1:0];
                    n_state    = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    // stall check sees the new rpm and the old duty
                    n_duty     = r_duty_new;
                    n_out_vld  = 1'b1;
                    n_out_data = {2'b0, stall, r_rpm, r_duty_new};
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last_tach <= 1'b0;
            r_pulse_cnt <= '0;
            r_win       <= '0;
            r_rpm       <= '0;
            r_duty      <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last_tach <= n_last_tach;
            r_pulse_cnt <= n_pulse_cnt;
            r_win       <= n_win;
            r_rpm       <= n_rpm;
            r_duty      <= n_duty;
            r_out_vld   <= n_out_vld;
        end
        r_rpm_dvd  <= n_rpm_dvd;
        r_duty_dvd <= n_duty_dvd;
        r_duty_dvs <= n_duty_dvs;
        r_duty_new <= n_duty_new;
        r_out_data <= n_out_data;
    end

    fantc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    a_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !div_rsp.busy)
        else $error("divider busy while idle");

    a_rpm_then_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RPM_WAIT) && div_rsp.done |=> r_state == S_DUTY_GO)
        else $error("duty step skipped after rpm");

    a_win_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && win_close |=> (r_pulse_cnt == '0) && (r_win == '0))
        else $error("window did not clear");

    a_stall_rpm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_data[29] |-> r_out_data[28:8] == '0)
        else $error("stall flagged with nonzero rpm");

endmodule

/* rtl/fantc_div.sv */
module fantc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fantc_pkg::t_div_req i_req,
    output fantc_pkg::t_div_rsp o_rsp
);

    logic [fantc_pkg::DVS_W-1:0]  r_rem, n_rem;
    logic [fantc_pkg::DVD_W-1:0]  r_work, n_work;
    logic [fantc_pkg::DVS_W-1:0]  r_dvs, n_dvs;
    logic [fantc_pkg::DCNT_W-1:0] r_cnt, n_cnt;
    logic                         r_busy, n_busy;
    logic                         r_done, n_done;

    logic [fantc_pkg::DVS_W:0]    shifted;
    logic [fantc_pkg::DVS_W:0]    diff;
    logic                         ge;

    // one restoring shift-subtract step per cycle while busy
    always_comb begin
        shifted = {r_rem, r_work[fantc_pkg::DVD_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = shifted >= {1'b0, r_dvs};

        n_rem  = r_rem;
        n_work = r_work;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;

        if (i_req.start) begin
            n_rem  = '0;
            n_work = i_req.dividend;
            n_dvs  = i_req.divisor;
            n_cnt  = fantc_pkg::DCNT_W'(fantc_pkg::DVD_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = ge ? diff[fantc_pkg::DVS_W-1:0] : shifted[fantc_pkg::DVS_W-1:0];
            n_work = {r_work[fantc_pkg::DVD_W-2:0], ge};
            n_cnt  = r_cnt - 1'b1;
            if (r_cnt == fantc_pkg::DCNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_work <= n_work;
        r_dvs  <= n_dvs;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_work;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");

    a_done_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_cnt == '0)
        else $error("divider done before last step");

endmodule

/* verif/tb_fan_tach_and_temp_duty_control_top.sv */
`timescale 1ns / 100ps

module tb_fan_tach_and_temp_duty_control_top;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 235;

    typedef struct packed {
        logic                                tick;
        logic signed [fantc_pkg::TEMP_W-1:0] room;
        logic signed [fantc_pkg::TEMP_W-1:0] thermo;
        logic                                tach;
    } t_fan_sample;

    typedef struct {
        logic [fantc_pkg::DUTY_W-1:0] duty;
        logic [fantc_pkg::RPM_W-1:0]  rpm;
        logic                         stall;
    } t_fan_status;

    class t_fan_ctrl_scoreboard;
        logic                               manual_mode;
        logic [fantc_pkg::SPEED_W-1:0]      manual_speed;
        logic signed [fantc_pkg::OFS_W-1:0] temp_offset;
        logic [fantc_pkg::SCALE_W-1:0]      scale_max;

        logic                               tach_was_high;
        logic [fantc_pkg::PCNT_W-1:0]       pulse_cnt;
        logic [fantc_pkg::WIN_W-1:0]        window_ms;
        logic [fantc_pkg::RPM_W-1:0]        rpm_latched;
        logic [fantc_pkg::DUTY_W-1:0]       duty_now;

        t_fan_status                        status_q[$];
        int                                 errors;

        function new();
            manual_mode   = 1'b0;
            manual_speed  = '0;
            temp_offset   = '0;
            scale_max     = fantc_pkg::SCALE_RST;
            tach_was_high = 1'b0;
            pulse_cnt     = '0;
            window_ms     = '0;
            rpm_latched   = '0;
            duty_now      = '0;
            errors        = 0;
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(logic [fantc_pkg::CFG_IDX_W-1:0] idx,
                                logic [fantc_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                fantc_pkg::CFG_MANUAL_MODE:  manual_mode  = val[0];
                fantc_pkg::CFG_MANUAL_SPEED: manual_speed = val[fantc_pkg::SPEED_W-1:0];
                fantc_pkg::CFG_TEMP_OFFSET:  temp_offset  = val[fantc_pkg::OFS_W-1:0];
                fantc_pkg::CFG_SCALE_MAX:    scale_max    = val[fantc_pkg::SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        // advance the fan state by one sample and queue the status it produces
        function void note_sample(t_fan_sample s);
            int          rpm_calc;
            int          speed;
            int          degrees;
            int          divisor;
            int          duty;
            t_fan_status e;
            if (s.tach && !tach_was_high && pulse_cnt != '1)
                pulse_cnt++;
            tach_was_high = s.tach;
            if (s.tick) begin
                window_ms++;
                if (int'(window_ms) >= fantc_pkg::WINDOW_TICKS_DEF) begin
                    rpm_calc    = int'(pulse_cnt) * 60 / fantc_pkg::PULSES_PER_REV_DEF;
                    rpm_latched = (rpm_calc > int'(fantc_pkg::RPM_MAX))
                                ? fantc_pkg::RPM_MAX : fantc_pkg::RPM_W'(rpm_calc);
                    pulse_cnt   = '0;
                    window_ms   = '0;
                end
            end
            // stall looks at the duty from the previous sample
            e.stall = (rpm_latched == '0) && (duty_now != '0);
            if (manual_mode) begin
                speed = (manual_speed > fantc_pkg::SPEED_MAX) ? int'(fantc_pkg::SPEED_MAX)
                                                               : int'(manual_speed);
                duty  = speed * int'(fantc_pkg::DUTY_MAX) / int'(fantc_pkg::PCT_DIV);
            end else if (int'(s.room) > int'(s.thermo) + int'(temp_offset) * 16) begin
                // offset only gates, the difference itself ignores it
                degrees = (int'(s.room) - int'(s.thermo)) / 16;
                divisor = (scale_max == '0) ? 1 : int'(scale_max);
                duty    = degrees * int'(fantc_pkg::DUTY_MAX) / divisor;
                if (duty < 0)
                    duty = 0;
                if (duty > int'(fantc_pkg::DUTY_MAX))
                    duty = int'(fantc_pkg::DUTY_MAX);
            end else begin
                duty = 0;
            end
            duty_now = fantc_pkg::DUTY_W'(duty);
            e.duty   = duty_now;
            e.rpm    = rpm_latched;
            status_q.push_back(e);
        endfunction

        function int pending();
            return status_q.size();
        endfunction

        task check_result(logic [fantc_pkg::OUT_DATA_W-1:0] d);
            t_fan_status e;
            if (status_q.size() == 0) begin
                report($sformatf("unexpected result 0x%08h", d));
            end else begin
                e = status_q.pop_front();
                if (d[7:0] !== e.duty)
                    report($sformatf("duty %0d, want %0d", d[7:0], e.duty));
                if (d[28:8] !== e.rpm)
                    report($sformatf("rpm %0d, want %0d", d[28:8], e.rpm));
                if (d[29] !== e.stall)
                    report($sformatf("stall %0b, want %0b", d[29], e.stall));
            end
        endtask
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [fantc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [fantc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                             i_cfg_we = 1'b0;
    logic [fantc_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [fantc_pkg::CFG_DATA_W-1:0] i_cfg_wdata = '0;

    t_fan_ctrl_scoreboard sb;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int ticks_sent = 0;

    fan_tach_and_temp_duty_control_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    always @(negedge i_clk) begin
        m_axis_tready <= (int'($urandom_range(99)) >= sink_stall_pct);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_sample(logic tach, int thermo, int room, logic tick);
        t_fan_sample s;
        s.tach   = tach;
        s.thermo = thermo[fantc_pkg::TEMP_W-1:0];
        s.room   = room[fantc_pkg::TEMP_W-1:0];
        s.tick   = tick;
        while (int'($urandom_range(99)) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= fantc_pkg::IN_DATA_W'(s);
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_sample(s);
        if (tick)
            ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic apply_settings(logic mode, int speed, int offset, int scale);
        logic [fantc_pkg::CFG_IDX_W-1:0]  idx [4];
        logic [fantc_pkg::CFG_DATA_W-1:0] val [4];
        idx[0] = fantc_pkg::CFG_MANUAL_MODE;
        val[0] = fantc_pkg::CFG_DATA_W'(mode);
        idx[1] = fantc_pkg::CFG_MANUAL_SPEED;
        val[1] = fantc_pkg::CFG_DATA_W'(speed[fantc_pkg::SPEED_W-1:0]);
        idx[2] = fantc_pkg::CFG_TEMP_OFFSET;
        val[2] = fantc_pkg::CFG_DATA_W'(offset[fantc_pkg::OFS_W-1:0]);
        idx[3] = fantc_pkg::CFG_SCALE_MAX;
        val[3] = fantc_pkg::CFG_DATA_W'(scale[fantc_pkg::SCALE_W-1:0]);
        for (int k = 0; k < 4; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= idx[k];
            i_cfg_wdata <= val[k];
            sb.write_reg(idx[k], val[k]);
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    task automatic send_random_sample();
        logic tach;
        logic tick;
        int   thermo;
        int   room;
        // alternate windows: random tach, silent tach, fastest toggling
        case ((ticks_sent / fantc_pkg::WINDOW_TICKS_DEF) % 3)
            0:       tach = 1'($urandom_range(1));
            1:       tach = 1'b0;
            default: tach = ~sb.tach_was_high;
        endcase
        tick   = (int'($urandom_range(99)) < 97);
        thermo = int'($urandom_range(4095)) - 2048;
        if ($urandom_range(1)) begin
            room = thermo + int'($urandom_range(767)) - 256;
            if (room > 2047)
                room = 2047;
            if (room < -2048)
                room = -2048;
        end else begin
            room = int'($urandom_range(4095)) - 2048;
        end
        send_sample(tach, thermo, room, tick);
    endtask

    initial begin
        sb = new;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: automatic, no offset, scale 10
        send_sample(1'b1, 0, 0, 1'b1);
        send_sample(1'b0, -2048, 2047, 1'b0);
        send_sample(1'b1, 2047, -2048, 1'b1);
        send_sample(1'b0, 0, 17, 1'b1);
        send_sample(1'b1, 0, 15, 1'b0);
        send_sample(1'b0, 100, 100, 1'b1);
        send_sample(1'b1, -16, -1, 1'b1);
        wait_drained();

        // most negative offset, zero scale acts as one
        apply_settings(1'b0, 0, -64, 0);
        send_sample(1'b0, 0, -100, 1'b1);
        send_sample(1'b1, 0, 32, 1'b1);
        send_sample(1'b0, 2047, -2048, 1'b1);
        send_sample(1'b1, 2047, 1024, 1'b0);
        wait_drained();

        apply_settings(1'b0, 0, 63, 255);
        send_sample(1'b0, -2048, 2047, 1'b1);
        send_sample(1'b1, 0, 1000, 1'b1);
        send_sample(1'b0, 0, 1009, 1'b1);
        wait_drained();

        // manual speeds, including above 100
        apply_settings(1'b1, 127, 0, 10);
        send_sample(1'b1, 0, 2047, 1'b1);
        wait_drained();
        apply_settings(1'b1, 100, 0, 10);
        send_sample(1'b0, 0, 0, 1'b1);
        wait_drained();
        apply_settings(1'b1, 101, 0, 10);
        send_sample(1'b1, 0, 0, 1'b1);
        wait_drained();
        apply_settings(1'b1, 0, 0, 10);
        send_sample(1'b0, 0, 0, 1'b1);
        wait_drained();
        apply_settings(1'b1, 1, 0, 10);
        send_sample(1'b1, 0, 0, 1'b1);
        wait_drained();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph)
                0: apply_settings(1'b0, 0, 0, 10);
                1: apply_settings(1'b1, 100, 0, 10);
                2: apply_settings(1'b0, 50, -64, 1);
                3: apply_settings(1'b0, 0, 63, 255);
                4: apply_settings(1'b1, int'($urandom_range(127)), 5, 20);
                default: apply_settings(1'($urandom_range(1)), int'($urandom_range(127)),
                                        int'($urandom_range(127)) - 64,
                                        int'($urandom_range(255)));
            endcase
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 51; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 51; end
                default: begin src_idle_pct = 26; sink_stall_pct = 26; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_sample();
            wait_drained();
        end

        repeat (60) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d samples never produced a result", sb.pending()));
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/fantc_pkg.sv
rtl/fantc_div.sv
rtl/fan_tach_and_temp_duty_control_top.sv
verif/tb_fan_tach_and_temp_duty_control_top.sv
